>>> hw/rtl/byte_to_coeff_packer_core_assert.svh
// Assertion macros shared by the byte-to-coefficient packer modules.
`ifndef BYTE_TO_COEFF_PACKER_CORE_ASSERT_SVH
`define BYTE_TO_COEFF_PACKER_CORE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define BTC_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("packer invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define BTC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("packer same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("packer next-cycle check failed");

`endif

>>> hw/rtl/btc_pkg.sv
// Shared types and constants of the byte-to-coefficient packer.
package btc_pkg;

    localparam int unsigned BYTE_BITS   = 8;
    localparam int unsigned WIDTH_W     = 7;
    localparam int unsigned CNT_W       = 16;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [WIDTH_W-1:0] RESET_COEFF_BITS = 7'd16;
    localparam logic [CNT_W-1:0]   RESET_MAX_COEFFS = 16'd4096;
    localparam logic [CNT_W-1:0]   CNT_MAX          = 16'hFFFF;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEFF_BITS = 1'b0,
        CFG_MAX_COEFFS = 1'b1
    } t_cfg_idx;

    // One queued input byte.
    typedef struct packed {
        logic [BYTE_BITS-1:0] data_byte;
        logic                 last_byte;
    } t_item;

    // Configuration seen by the back end.
    typedef struct packed {
        logic                restart;
        logic [WIDTH_W-1:0]  width;
        logic [WIDTH_W-1:0]  restart_width;
        logic [CNT_W-1:0]    max_coeffs;
    } t_ctl;

endpackage

>>> hw/rtl/btc_byte_if.sv
// Input byte channel: valid/ready handshake with one byte and its last flag.
interface btc_byte_if;
    logic                          valid;
    logic                          ready;
    logic [btc_pkg::BYTE_BITS-1:0] data_byte;
    logic                          last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> hw/rtl/btc_coeff_if.sv
// Output coefficient channel: valid/ready handshake with one coefficient and its tags.
interface btc_coeff_if #(
    parameter int unsigned VALUE_W = 60,
    parameter int unsigned INDEX_W = 15
);
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] coeff_value;
    logic [INDEX_W-1:0] coeff_index;
    logic               record_end;
    logic               overflow;

    modport source (output valid, output coeff_value, output coeff_index,
                    output record_end, output overflow, input ready);
    modport sink   (input valid, input coeff_value, input coeff_index,
                    input record_end, input overflow, output ready);
endinterface

>>> hw/rtl/btc_front.sv
// Front end: accepts input bytes and holds them in a short queue for the back end.
`include "byte_to_coeff_packer_core_assert.svh"

module btc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    btc_byte_if.sink       i_byte,
    output btc_pkg::t_item o_head,
    output logic           o_head_valid,
    input  logic           i_pop
);

    btc_pkg::t_item                   r_mem [btc_pkg::QUEUE_DEPTH];
    logic [btc_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [btc_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [btc_pkg::QCNT_W-1:0]       r_count;
    logic [btc_pkg::QCNT_W-1:0]       n_count;
    logic                             push;
    logic                             pop;

    // Handshake and queue status.
    assign i_byte.ready = (r_count != btc_pkg::QCNT_W'(btc_pkg::QUEUE_DEPTH));
    assign push         = i_byte.valid && i_byte.ready;
    assign o_head_valid = (r_count != '0);
    assign pop          = i_pop && o_head_valid;
    assign o_head       = r_mem[r_rd_ptr];

    // Occupancy after this cycle's transfers.
    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // Queue storage; each transfer lands at the write pointer.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= {i_byte.data_byte, i_byte.last_byte};
        end
    end

    `BTC_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= btc_pkg::QCNT_W'(btc_pkg::QUEUE_DEPTH))
    `BTC_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != '0)
    `BTC_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, push && !pop, r_count == $past(r_count) + 1'b1)

endmodule

>>> hw/rtl/btc_back.sv
// Back end: packs queued bytes into coefficients, at most one coefficient per cycle.
`include "byte_to_coeff_packer_core_assert.svh"

module btc_back #(
    parameter int unsigned COEFF_WIDTH = 60,
    parameter int unsigned MAX_DEGREE  = 32768
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  btc_pkg::t_ctl  i_ctl,
    input  btc_pkg::t_item i_head,
    input  logic           i_head_valid,
    output logic           o_pop,
    btc_coeff_if.source    o_coeff
);

    localparam int unsigned IDX_W = $clog2(MAX_DEGREE);
    localparam logic [btc_pkg::WIDTH_W-1:0] RESET_WIDTH =
        (int'(btc_pkg::RESET_COEFF_BITS) > COEFF_WIDTH) ?
        btc_pkg::WIDTH_W'(COEFF_WIDTH) : btc_pkg::RESET_COEFF_BITS;
    localparam logic [btc_pkg::CNT_W-1:0] IDX_LAST = btc_pkg::CNT_W'(MAX_DEGREE - 1);

    // Record state.
    logic [COEFF_WIDTH-1:0]          r_part, n_part;
    logic [btc_pkg::WIDTH_W-1:0]     r_free, n_free;
    logic [btc_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic [2:0]                      r_off, n_off;
    logic                            r_pad, n_pad;

    // Output register.
    logic                            r_ovalid;
    logic [COEFF_WIDTH-1:0]          r_ovalue;
    logic [IDX_W-1:0]                r_oindex;
    logic                            r_oend;
    logic                            r_oovf;

    // Step datapath.
    logic [btc_pkg::BYTE_BITS-1:0]   bits;
    logic [btc_pkg::BYTE_BITS-1:0]   bits_rest;
    logic [3:0]                      rem;
    logic [3:0]                      fill;
    logic [3:0]                      rest;
    logic                            fills;
    logic [COEFF_WIDTH-1:0]          val_full;
    logic [COEFF_WIDTH-1:0]          part_rest;
    logic [COEFF_WIDTH-1:0]          part_all;
    logic [btc_pkg::WIDTH_W-1:0]     free_all;
    logic [COEFF_WIDTH-1:0]          e_val;
    logic                            e_end;
    logic                            emit;
    logic                            done;
    logic                            restart_rec;
    logic                            out_free;
    logic                            step;
    logic [IDX_W-1:0]                e_idx;
    logic                            e_ovf;

    // Remaining bits of the head byte, aligned at the top.
    always_comb begin
        bits      = btc_pkg::BYTE_BITS'(i_head.data_byte << r_off);
        rem       = 4'd8 - {1'b0, r_off};
        fill      = r_free[3:0];
        fills     = (r_free <= {3'b000, rem});
        rest      = rem - fill;
        bits_rest = btc_pkg::BYTE_BITS'(bits << fill);
        val_full  = COEFF_WIDTH'(r_part << r_free) | COEFF_WIDTH'(bits >> (4'd8 - fill));
        part_rest = COEFF_WIDTH'(bits_rest >> (4'd8 - rest));
        part_all  = COEFF_WIDTH'(r_part << rem) | COEFF_WIDTH'(bits >> (4'd8 - rem));
        free_all  = r_free - {3'b000, rem};
    end

    // Step control: each step absorbs the head byte up to and including one coefficient.
    always_comb begin
        n_part      = r_part;
        n_free      = r_free;
        n_off       = r_off;
        n_pad       = r_pad;
        emit        = 1'b0;
        e_val       = '0;
        e_end       = 1'b0;
        done        = 1'b0;
        restart_rec = 1'b0;
        if (i_head_valid) begin
            if (r_pad) begin
                // Flush of a partly filled coefficient left by the last byte.
                emit        = 1'b1;
                e_val       = COEFF_WIDTH'(r_part << r_free);
                e_end       = 1'b1;
                done        = 1'b1;
                restart_rec = 1'b1;
            end else if (fills) begin
                emit  = 1'b1;
                e_val = val_full;
                if (rest == 4'd0) begin
                    e_end       = i_head.last_byte;
                    done        = 1'b1;
                    n_part      = '0;
                    n_free      = i_ctl.width;
                    n_off       = '0;
                    restart_rec = i_head.last_byte;
                end else if ({3'b000, rest} >= i_ctl.width) begin
                    // Enough bits left for another full coefficient.
                    n_part = '0;
                    n_free = i_ctl.width;
                    n_off  = r_off + fill[2:0];
                end else begin
                    n_part = part_rest;
                    n_free = i_ctl.width - {3'b000, rest};
                    if (i_head.last_byte) begin
                        n_pad = 1'b1;
                    end else begin
                        done  = 1'b1;
                        n_off = '0;
                    end
                end
            end else begin
                n_part = part_all;
                n_free = free_all;
                n_off  = '0;
                done   = 1'b1;
                if (i_head.last_byte) begin
                    emit        = 1'b1;
                    e_val       = COEFF_WIDTH'(part_all << free_all);
                    e_end       = 1'b1;
                    restart_rec = 1'b1;
                end
            end
        end
    end

    // Step gating and coefficient tags.
    always_comb begin
        out_free = !r_ovalid || o_coeff.ready;
        step     = i_head_valid && (!emit || out_free);
        e_idx    = (r_cnt > IDX_LAST) ? IDX_W'(MAX_DEGREE - 1) : r_cnt[IDX_W-1:0];
        e_ovf    = (r_cnt >= i_ctl.max_coeffs);
        n_cnt    = r_cnt;
        if (step && emit && (r_cnt != btc_pkg::CNT_MAX)) begin
            n_cnt = r_cnt + 1'b1;
        end
        if (step && restart_rec) begin
            n_cnt = '0;
        end
    end

    assign o_pop = step && done;

    // Record state registers; a width write restarts the record.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part <= '0;
            r_free <= RESET_WIDTH;
            r_cnt  <= '0;
            r_off  <= '0;
            r_pad  <= 1'b0;
        end else if (i_ctl.restart) begin
            r_part <= '0;
            r_free <= i_ctl.restart_width;
            r_cnt  <= '0;
            r_off  <= '0;
            r_pad  <= 1'b0;
        end else if (step && restart_rec) begin
            r_part <= '0;
            r_free <= i_ctl.width;
            r_cnt  <= '0;
            r_off  <= '0;
            r_pad  <= 1'b0;
        end else if (step) begin
            r_part <= n_part;
            r_free <= n_free;
            r_cnt  <= n_cnt;
            r_off  <= n_off;
            r_pad  <= n_pad;
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_free) begin
            r_ovalid <= step && emit;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_ovalue <= e_val;
            r_oindex <= e_idx;
            r_oend   <= e_end;
            r_oovf   <= e_ovf;
        end
    end

    assign o_coeff.valid       = r_ovalid;
    assign o_coeff.coeff_value = r_ovalue;
    assign o_coeff.coeff_index = r_oindex;
    assign o_coeff.record_end  = r_oend;
    assign o_coeff.overflow    = r_oovf;

    `BTC_ASSERT_ALWAYS(a_free_range, i_clk, i_rst_n, (r_free != '0) && (r_free <= i_ctl.width))
    `BTC_ASSERT_IMPL(a_pad_holds_head, i_clk, i_rst_n, r_pad, i_head_valid && i_head.last_byte)
    `BTC_ASSERT_NEXT(a_end_restarts, i_clk, i_rst_n, step && emit && e_end, r_cnt == '0)

endmodule

>>> hw/rtl/byte_to_coeff_packer_core.sv
// A byte passes through the front-end queue before its first coefficient is registered at
// the output. Throughput while the output is not stalled: one byte per cycle for widths of 8
// or more, but a byte that fills a coefficient and also ends the record with a padded one
// stays at the head while the padded one is flushed; for widths under 8, one coefficient per
// cycle. Reset (synchronous, active low) empties the queue and output and restores width 16
// and limit 4096 with an empty record; no clearing pass.
module byte_to_coeff_packer_core #(
    parameter int unsigned COEFF_WIDTH = 60,
    parameter int unsigned MAX_DEGREE  = 32768
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    btc_byte_if.sink                           i_byte,
    btc_coeff_if.source                        o_coeff,
    input  logic                               i_cfg_we,
    input  logic [btc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [btc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam logic [btc_pkg::WIDTH_W-1:0] RESET_WIDTH =
        (int'(btc_pkg::RESET_COEFF_BITS) > COEFF_WIDTH) ?
        btc_pkg::WIDTH_W'(COEFF_WIDTH) : btc_pkg::RESET_COEFF_BITS;

    logic [btc_pkg::WIDTH_W-1:0] r_width;
    logic [btc_pkg::CNT_W-1:0]   r_max_coeffs;
    logic [btc_pkg::WIDTH_W-1:0] new_width;
    logic                        width_wr;
    btc_pkg::t_ctl               ctl;
    btc_pkg::t_item              head;
    logic                        head_valid;
    logic                        pop;

    // Width from the low six bits of a written value: zero acts as one, large values clamp.
    always_comb begin
        new_width = {1'b0, i_cfg_data[5:0]};
        if (new_width == '0) begin
            new_width = btc_pkg::WIDTH_W'(1);
        end else if (new_width > btc_pkg::WIDTH_W'(COEFF_WIDTH)) begin
            new_width = btc_pkg::WIDTH_W'(COEFF_WIDTH);
        end
    end

    assign width_wr = i_cfg_we && (i_cfg_idx == btc_pkg::CFG_COEFF_BITS);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= RESET_WIDTH;
            r_max_coeffs <= btc_pkg::RESET_MAX_COEFFS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                btc_pkg::CFG_COEFF_BITS: begin
                    r_width <= new_width;
                end
                btc_pkg::CFG_MAX_COEFFS: begin
                    r_max_coeffs <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Control bundle for the back end.
    always_comb begin
        ctl.restart       = width_wr;
        ctl.width         = r_width;
        ctl.restart_width = new_width;
        ctl.max_coeffs    = r_max_coeffs;
    end

    btc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (i_byte),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_pop        (pop)
    );

    btc_back #(
        .COEFF_WIDTH (COEFF_WIDTH),
        .MAX_DEGREE  (MAX_DEGREE)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_coeff      (o_coeff)
    );

endmodule

>>> test/byte_to_coeff_packer_core_test.sv
// Self-checking testbench of the byte-to-coefficient packer with its own coefficient predictor.
package btc_test_pkg;
    import btc_pkg::*;

    // One coefficient as it leaves the packer.
    typedef struct packed {
        logic [59:0] value;
        logic [14:0] index;
        logic        rec_end;
        logic        ovf;
    } t_coeff;

    class coeff_scoreboard;
        localparam int unsigned VALUE_W   = 60;
        localparam int unsigned INDEX_SAT = 32767;

        bit [5:0]    width_reg;
        bit [15:0]   limit_reg;
        bit [63:0]   partial;
        int unsigned free_bits;
        bit [15:0]   emitted;
        t_coeff      coeff_q[$];
        bit [63:0]   widths_seen;
        int unsigned errors;
        int unsigned bytes_in;
        int unsigned records;
        int unsigned coeffs_ok;
        int unsigned overflows;
        int unsigned padded;

        function new();
            width_reg = RESET_COEFF_BITS[5:0];
            limit_reg = RESET_MAX_COEFFS;
            restart();
        endfunction

        function int unsigned cur_width();
            int unsigned w;
            w = width_reg;
            if (w == 0) w = 1;
            if (w > VALUE_W) w = VALUE_W;
            return w;
        endfunction

        function bit [63:0] low_mask(int unsigned n);
            if (n >= 64) return '1;
            return (64'd1 << n) - 64'd1;
        endfunction

        function void restart();
            partial   = '0;
            free_bits = cur_width();
            emitted   = '0;
        endfunction

        // A write of the width also starts a new record.
        function void write_reg(t_cfg_idx idx, logic [15:0] data);
            case (idx)
                CFG_COEFF_BITS: begin
                    width_reg = data[5:0];
                    restart();
                end
                CFG_MAX_COEFFS: begin
                    limit_reg = data;
                end
                default: ;
            endcase
        endfunction

        function void push_coeff(bit [63:0] value, bit rec_end);
            t_coeff c;
            c.value   = value & low_mask(cur_width());
            c.index   = (emitted > INDEX_SAT) ? INDEX_SAT[14:0] : emitted[14:0];
            c.rec_end = rec_end;
            c.ovf     = (emitted >= limit_reg);
            coeff_q.push_back(c);
            if (emitted != CNT_MAX) emitted++;
        endfunction

        // Shift one accepted byte into the record, most significant bit first.
        function void note_byte(logic [7:0] data_byte, logic last_byte);
            int unsigned w;
            int unsigned remain;
            int unsigned n;
            bit [7:0]    b;
            bit [63:0]   top;
            w      = cur_width();
            b      = data_byte;
            remain = BYTE_BITS;
            bytes_in++;
            widths_seen[w] = 1'b1;
            if (free_bits == 0 || free_bits > w) free_bits = w;
            while (remain > 0) begin
                n = (free_bits < remain) ? free_bits : remain;
                top = ({56'd0, b} >> (BYTE_BITS - n)) & low_mask(n);
                partial = ((partial << n) | top) & low_mask(w);
                b = b << n;
                free_bits -= n;
                remain -= n;
                if (free_bits == 0) begin
                    push_coeff(partial, last_byte && remain == 0);
                    partial   = '0;
                    free_bits = w;
                end
            end
            if (last_byte) begin
                // A partly filled coefficient is padded with zeros at the low end.
                if (free_bits < w) begin
                    push_coeff(partial << free_bits, 1'b1);
                    padded++;
                end
                records++;
                restart();
            end
        endfunction

        function void check_coeff(t_coeff got);
            t_coeff exp_c;
            if (coeff_q.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: unexpected coefficient value %h index %0d end %0b ovf %0b",
                             $time, got.value, got.index, got.rec_end, got.ovf);
                return;
            end
            exp_c = coeff_q.pop_front();
            if (exp_c.ovf) overflows++;
            if (got !== exp_c) begin
                errors++;
                // Keep the log short when a run goes badly wrong.
                if (errors <= 40) begin
                    if (got.value !== exp_c.value)
                        $display("%0t: coeff_value expected %h actual %h",
                                 $time, exp_c.value, got.value);
                    if (got.index !== exp_c.index)
                        $display("%0t: coeff_index expected %0d actual %0d",
                                 $time, exp_c.index, got.index);
                    if (got.rec_end !== exp_c.rec_end)
                        $display("%0t: record_end expected %0b actual %0b",
                                 $time, exp_c.rec_end, got.rec_end);
                    if (got.ovf !== exp_c.ovf)
                        $display("%0t: overflow expected %0b actual %0b",
                                 $time, exp_c.ovf, got.ovf);
                end
            end else begin
                coeffs_ok++;
            end
        endfunction

        function int unsigned pending();
            return coeff_q.size();
        endfunction
    endclass
endpackage

module byte_to_coeff_packer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import btc_pkg::*;
    import btc_test_pkg::*;

    localparam int unsigned SETTLE = 8;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    btc_byte_if                                   byte_ch ();
    btc_coeff_if #(.VALUE_W(60), .INDEX_W(15))    coeff_ch ();

    coeff_scoreboard sb;
    bit              tx_idle;
    bit              rx_idle;
    int unsigned     hold_cycles;

    byte_to_coeff_packer_core #(
        .COEFF_WIDTH (60),
        .MAX_DEGREE  (32768)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (byte_ch),
        .o_coeff    (coeff_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Overall time limit.
    initial begin
        #20ms;
        $display("byte_to_coeff_packer_core_test: FAIL");
        $finish;
    end

    // Coefficient receiver: checks each transfer, then picks ready for the next cycle.
    initial begin
        int unsigned stall_left;
        t_coeff      got;
        stall_left = 0;
        coeff_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && coeff_ch.valid && coeff_ch.ready) begin
                got.value   = coeff_ch.coeff_value;
                got.index   = coeff_ch.coeff_index;
                got.rec_end = coeff_ch.record_end;
                got.ovf     = coeff_ch.overflow;
                sb.check_coeff(got);
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                coeff_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                coeff_ch.ready <= 1'b0;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                coeff_ch.ready <= 1'b0;
            end else begin
                coeff_ch.ready <= 1'b1;
            end
        end
    end

    // Register write; the block is idle whenever this is called.
    task automatic cfg_write(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offers one byte, with an optional gap first, and returns on its transfer.
    task automatic send_byte(logic [7:0] data_byte, logic last_byte);
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= data_byte;
        byte_ch.last_byte <= last_byte;
        do @(posedge i_clk); while (!(byte_ch.valid && byte_ch.ready));
        sb.note_byte(data_byte, last_byte);
    endtask

    task automatic send_record(int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_byte(8'($urandom), i == len - 1);
    endtask

    // Stops offering and waits until every predicted coefficient has come out.
    task automatic wait_results();
        byte_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int unsigned sent;
        int unsigned len;
        int unsigned width_pick;
        logic [15:0] limit_pick;

        sb          = new();
        tx_idle     = 1'b0;
        rx_idle     = 1'b0;
        hold_cycles = 0;
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= CFG_COEFF_BITS;
        cfg_data          <= '0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= '0;
        byte_ch.last_byte <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset width 16: field extremes and a padded tail.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h80, 1'b1);
        wait_results();

        // The last byte fills a coefficient exactly, so no padding follows.
        cfg_write(CFG_COEFF_BITS, 16'd8);
        send_byte(8'hFF, 1'b1);
        wait_results();

        // Width zero behaves as one bit: eight coefficients from one byte.
        cfg_write(CFG_COEFF_BITS, 16'd0);
        send_byte(8'hC3, 1'b1);
        wait_results();

        // Width above the coefficient size is clamped to 60 bits.
        cfg_write(CFG_COEFF_BITS, 16'd63);
        for (int i = 0; i < 7; i++) send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);
        wait_results();

        // A limit of zero flags every coefficient.
        cfg_write(CFG_COEFF_BITS, 16'd12);
        cfg_write(CFG_MAX_COEFFS, 16'd0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h01, 1'b1);
        wait_results();

        // A limit of one flags everything past the first coefficient.
        cfg_write(CFG_COEFF_BITS, 16'd4);
        cfg_write(CFG_MAX_COEFFS, 16'd1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
        wait_results();

        // A width change in the middle of a record drops its partial coefficient.
        cfg_write(CFG_COEFF_BITS, 16'd5);
        cfg_write(CFG_MAX_COEFFS, 16'hFFFF);
        send_byte(8'h5A, 1'b0);
        wait_results();
        cfg_write(CFG_COEFF_BITS, 16'd7);
        send_byte(8'h81, 1'b1);
        wait_results();

        // Random records over a series of widths and limits; the last phase runs without gaps.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: width_pick = 1;
                1: width_pick = 60;
                2: width_pick = 8;
                3: width_pick = 61;
                default: width_pick = $urandom_range(0, 63);
            endcase
            case ($urandom_range(0, 3))
                0: limit_pick = 16'($urandom_range(0, 3));
                1: limit_pick = 16'($urandom_range(4, 40));
                2: limit_pick = 16'hFFFF;
                default: limit_pick = 16'($urandom);
            endcase
            tx_idle = ((phase % 3) != 2) && (phase < 7);
            rx_idle = ((phase % 2) == 0) && (phase < 7);
            cfg_write(CFG_COEFF_BITS, 16'(width_pick));
            cfg_write(CFG_MAX_COEFFS, limit_pick);

            // The receiver holds off for a long stretch while bytes keep coming.
            if (phase == 3) hold_cycles = 200;

            sent = 0;
            while (sent < 40) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 30)
                                                  : $urandom_range(1, 8);
                if (len > 40 - sent) len = 40 - sent;
                // Now and then leave the record open; the next width write ends it.
                if (sent + len == 40 && $urandom_range(0, 2) == 0) begin
                    for (int unsigned i = 0; i < len; i++)
                        send_byte(8'($urandom), 1'b0);
                end else begin
                    send_record(len);
                end
                sent += len;
                // In phase 5 the sender pauses once, midway, until every coefficient so far has come out.
                if (phase == 5 && sent >= 20 && sent < 20 + len) wait_results();
            end
            wait_results();
        end

        if (sb.pending() != 0)
            $display("%0t: %0d coefficients never arrived", $time, sb.pending());
        $display("Covered %0d bytes in %0d records over %0d distinct widths.",
                 sb.bytes_in, sb.records, $countones(sb.widths_seen));
        $display("Matched %0d coefficients, %0d flagged overflow, %0d padded at record end.",
                 sb.coeffs_ok, sb.overflows, sb.padded);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("byte_to_coeff_packer_core_test: PASS");
        end else begin
            $display("byte_to_coeff_packer_core_test: FAIL");
        end
        $finish;
    end
endmodule
